### hdl/wcs_pkg.sv
// ----------------------------------------------------------------------------
// wcs_pkg
// shared types, codes and widths of the windowed counter statistics block
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int KeysDefault   = 8;
    localparam int LevelsDefault = 4;
    localparam int CountW        = 32;
    localparam int TimeW         = 48;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 48;

    // operation codes
    localparam logic [1:0] OpAdd  = 2'd0;
    localparam logic [1:0] OpTick = 2'd1;
    localparam logic [1:0] OpThr  = 2'd2;
    localparam logic [1:0] OpRead = 2'd3;

    // result kinds
    localparam logic [1:0] ResAlarm = 2'd0;
    localparam logic [1:0] ResRead  = 2'd1;
    localparam logic [1:0] ResDone  = 2'd2;

    // statistic selectors
    localparam logic [2:0] StatCur  = 3'd0;
    localparam logic [2:0] StatLast = 3'd1;
    localparam logic [2:0] StatMin  = 3'd2;
    localparam logic [2:0] StatMax  = 3'd3;
    localparam logic [2:0] StatRoll = 3'd4;

    // register indexes
    localparam logic [2:0] CfgKeyCount = 3'd0;
    localparam logic [2:0] CfgPerSec   = 3'd1;
    localparam logic [2:0] CfgPerMin   = 3'd2;
    localparam logic [2:0] CfgPerHour  = 3'd3;
    localparam logic [2:0] CfgPerDay   = 3'd4;
    localparam logic [2:0] CfgAlarmEn  = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the input request
        logic do_add;    // add at the current sweep level
        logic do_thr;    // threshold write
        logic rd_req;    // read memories at the selected address
        logic sweep_wr;  // close update for the swept entry
        logic roll_lvl;  // bump roll count and start of the sweep level
        logic clr_lvl;   // reset level counter
        logic inc_lvl;   // next level
        logic clr_key;   // reset key counter
        logic inc_key;   // next key
        logic emit_alarm;
        logic emit_done;
        logic emit_read;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       lvl_last;   // level counter at last level
        logic       key_last;   // key counter at last active key
        logic       no_keys;    // no active keys
        logic       lvl_closes; // current level window closes
        logic       alarm_hit;  // swept entry raises an alarm
        logic       out_busy;   // output register full and stalled
    } t_status;

endpackage

### hdl/wcs_datapath.sv
// ----------------------------------------------------------------------------
// wcs_datapath
// counter memories, window registers, configuration and output register
// ----------------------------------------------------------------------------
module wcs_datapath #(
    parameter int KEYS   = wcs_pkg::KeysDefault,
    parameter int LEVELS = wcs_pkg::LevelsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcs_pkg::t_cmd                 i_cmd,
    output wcs_pkg::t_status              o_status,
    input  logic                          i_cfg_valid,
    input  logic [wcs_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [wcs_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_level,
    input  logic [2:0]                    i_key_index,
    input  logic [2:0]                    i_stat_kind,
    input  logic [31:0]                   i_amount,
    input  logic [47:0]                   i_now_time,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_result_kind,
    output logic [1:0]                    o_alarm_level,
    output logic [2:0]                    o_alarm_key,
    output logic [31:0]                   o_count_value,
    output logic [31:0]                   o_threshold_value,
    output logic [3:0]                    o_rolled_mask,
    output logic                          o_last_of_run
);
    import wcs_pkg::*;

    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int DEPTH = LEVELS * KEYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NKW   = $clog2(KEYS + 1);

    // configuration
    logic [3:0]       r_key_count;
    logic [TimeW-1:0] r_period [4];
    logic [3:0]       r_alarm_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 4'd8;
            r_period[0] <= 48'd1000;
            r_period[1] <= 48'd60000;
            r_period[2] <= 48'd3600000;
            r_period[3] <= 48'd86400000;
            r_alarm_en  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgKeyCount: r_key_count <= i_cfg_data[3:0];
                CfgPerSec:   r_period[0] <= i_cfg_data;
                CfgPerMin:   r_period[1] <= i_cfg_data;
                CfgPerHour:  r_period[2] <= i_cfg_data;
                CfgPerDay:   r_period[3] <= i_cfg_data;
                CfgAlarmEn:  r_alarm_en  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // active key count, clamped to KEYS
    logic [NKW-1:0] w_nk;
    always_comb begin
        if (32'(r_key_count) > 32'(KEYS)) w_nk = NKW'(KEYS);
        else                              w_nk = NKW'(r_key_count);
    end

    // captured request
    logic [1:0]       r_op, r_lvl_in;
    logic [2:0]       r_key_in, r_kind;
    logic [31:0]      r_amount;
    logic [TimeW-1:0] r_now;
    logic             r_key_ok, r_lvl_ok;
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_operation;
            r_lvl_in <= i_level;
            r_key_in <= i_key_index;
            r_kind   <= i_stat_kind;
            r_amount <= i_amount;
            r_now    <= i_now_time;
            r_key_ok <= {1'b0, i_key_index} < 4'(w_nk) && 32'(i_key_index) < KEYS;
            r_lvl_ok <= 32'(i_level) < LEVELS;
        end
    end

    // sweep counters
    logic [LW-1:0] r_lvl;
    logic [KW-1:0] r_key;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            r_key <= '0;
        end else begin
            if (i_cmd.clr_lvl)      r_lvl <= '0;
            else if (i_cmd.inc_lvl) r_lvl <= r_lvl + 1'b1;
            if (i_cmd.clr_key)      r_key <= '0;
            else if (i_cmd.inc_key) r_key <= r_key + 1'b1;
        end
    end

    // memory address: sweep key for ticks, request key otherwise
    logic [KW-1:0] w_key_sel;
    logic [LW-1:0] w_lvl_sel;
    logic [AW-1:0] w_addr;
    always_comb begin
        w_key_sel = (r_op == OpTick) ? r_key : KW'(r_key_in);
        w_lvl_sel = (r_op == OpRead || r_op == OpThr) ? LW'(r_lvl_in) : r_lvl;
        w_addr    = AW'(32'(w_lvl_sel) * KEYS + 32'(w_key_sel));
    end

    // per-level window state
    logic [TimeW-1:0] r_start [LEVELS];
    logic [31:0]      r_roll  [LEVELS];
    logic [3:0]       r_rolled;

    // counter memories with valid bits (cleared at reset)
    logic [31:0]      m_cur [DEPTH];
    logic [31:0]      m_last[DEPTH];
    logic [31:0]      m_min [DEPTH];
    logic [31:0]      m_max [DEPTH];
    logic [31:0]      m_thr [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_cur, r_last, r_min, r_max, r_thr;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_req) begin
            r_cur  <= m_cur[w_addr];
            r_last <= m_last[w_addr];
            r_min  <= m_min[w_addr];
            r_max  <= m_max[w_addr];
            r_thr  <= m_thr[w_addr];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rvld <= 1'b0;
        else if (i_cmd.rd_req) r_rvld <= r_vld[w_addr];
    end

    // read values, masked by valid
    logic [31:0] w_cur, w_last, w_min, w_max, w_thr, w_sum;
    logic [32:0] w_sum_full;
    always_comb begin
        w_cur      = r_rvld ? r_cur  : '0;
        w_last     = r_rvld ? r_last : '0;
        w_min      = r_rvld ? r_min  : '0;
        w_max      = r_rvld ? r_max  : '0;
        w_thr      = r_rvld ? r_thr  : '0;
        w_sum_full = {1'b0, w_cur} + {1'b0, r_amount};
        w_sum      = w_sum_full[32] ? 32'hFFFF_FFFF : w_sum_full[31:0];
    end

    // memory writes
    logic w_wr;
    always_comb w_wr = (i_cmd.do_add && r_key_ok) || (i_cmd.do_thr && r_key_ok && r_lvl_ok)
                       || i_cmd.sweep_wr;
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_cur[w_addr]  <= (i_cmd.do_add) ? w_sum : (i_cmd.sweep_wr ? 32'd0 : w_cur);
            m_thr[w_addr]  <= i_cmd.do_thr ? r_amount : w_thr;
            m_last[w_addr] <= i_cmd.sweep_wr ? w_cur : w_last;
            m_min[w_addr]  <= (i_cmd.sweep_wr && (w_min == 0 || w_cur < w_min)) ? w_cur : w_min;
            m_max[w_addr]  <= (i_cmd.sweep_wr && (w_max == 0 || w_cur > w_max)) ? w_cur : w_max;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_wr) r_vld[w_addr] <= 1'b1;
    end

    // window close test and roll update
    logic [TimeW-1:0] w_elapsed;
    logic             w_closes;
    always_comb begin
        w_elapsed = r_now - r_start[r_lvl];
        w_closes  = (r_now > r_start[r_lvl]) && (w_elapsed > r_period[2'(r_lvl)]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_start[l] <= '0;
                r_roll[l]  <= '0;
            end
            r_rolled <= '0;
        end else begin
            if (i_cmd.latch) r_rolled <= '0;
            if (i_cmd.roll_lvl) begin
                r_start[r_lvl] <= r_now;
                r_roll[r_lvl]  <= r_roll[r_lvl] + 1'b1;
                r_rolled[2'(r_lvl)] <= 1'b1;
            end
        end
    end

    // status
    always_comb begin
        o_status.op         = r_op;
        o_status.lvl_last   = 32'(r_lvl) == LEVELS - 1;
        o_status.key_last   = 32'(r_key) + 1 >= 32'(w_nk);
        o_status.no_keys    = w_nk == 0;
        o_status.lvl_closes = w_closes;
        o_status.alarm_hit  = r_alarm_en[2'(r_lvl)] && (w_cur > w_thr);
        o_status.out_busy   = o_out_valid && i_out_stall;
    end

    // read statistic
    logic [31:0] w_rd;
    always_comb begin
        w_rd = '0;
        if (r_lvl_ok) begin
            if (r_kind == StatRoll) w_rd = r_roll[LW'(r_lvl_in)];
            else if (r_key_ok) begin
                unique case (r_kind)
                    StatCur:  w_rd = w_cur;
                    StatLast: w_rd = w_last;
                    StatMin:  w_rd = w_min;
                    StatMax:  w_rd = w_max;
                    default:  w_rd = '0;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_alarm || i_cmd.emit_done || i_cmd.emit_read) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_alarm) begin
            o_result_kind     <= ResAlarm;
            o_alarm_level     <= 2'(r_lvl);
            o_alarm_key       <= 3'(r_key);
            o_count_value     <= w_cur;
            o_threshold_value <= w_thr;
            o_rolled_mask     <= '0;
            o_last_of_run     <= 1'b0;
        end else if (i_cmd.emit_read) begin
            o_result_kind     <= ResRead;
            o_alarm_level     <= r_lvl_in;
            o_alarm_key       <= r_key_in;
            o_count_value     <= w_rd;
            o_threshold_value <= '0;
            o_rolled_mask     <= '0;
            o_last_of_run     <= 1'b1;
        end else if (i_cmd.emit_done) begin
            o_result_kind     <= ResDone;
            o_alarm_level     <= '0;
            o_alarm_key       <= '0;
            o_count_value     <= '0;
            o_threshold_value <= '0;
            o_rolled_mask     <= (r_op == OpTick) ? r_rolled : 4'd0;
            o_last_of_run     <= 1'b1;
        end
    end

    // an emit never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(i_cmd.emit_alarm || i_cmd.emit_done ||
        i_cmd.emit_read)) else $error("result overwritten");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> $stable(o_count_value))
        else $error("stalled result changed");
    // a roll only happens at a closing level
    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.roll_lvl |-> w_closes) else $error("roll without close");

endmodule

### hdl/wcs_ctrl.sv
// ----------------------------------------------------------------------------
// wcs_ctrl
// sequencer for add, tick sweep, threshold write and read requests
// ----------------------------------------------------------------------------
module wcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wcs_pkg::t_status   i_status,
    output wcs_pkg::t_cmd      o_cmd
);
    import wcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EXEC, S_LVL, S_KRD, S_KWAIT, S_KEXEC, S_ROLL, S_DONE
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;

    always_comb o_in_stall = (r_state != S_IDLE);

    // capture strobe at the accepting edge, other commands registered
    always_comb begin
        o_cmd       = r_cmd;
        o_cmd.latch = (r_state == S_IDLE) && i_in_valid;
    end

    // add walks levels via S_RD/S_EXEC; tick sweeps each closing level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
        end else begin
            r_cmd <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd.clr_lvl <= 1'b1;
                        r_cmd.clr_key <= 1'b1;
                        r_state       <= S_RD;
                    end
                end
                S_RD: begin
                    if (i_status.op == OpTick) begin
                        r_state <= S_LVL;
                    end else begin
                        r_cmd.rd_req <= 1'b1;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // wait for the registered read
                    if (r_cmd.rd_req) begin
                        r_state <= S_EXEC;
                    end else if (i_status.op == OpAdd) begin
                        r_cmd.do_add <= 1'b1;
                        if (i_status.lvl_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cmd.inc_lvl <= 1'b1;
                            r_state       <= S_RD;
                        end
                    end else if (i_status.op == OpThr) begin
                        r_cmd.do_thr <= 1'b1;
                        r_state      <= S_DONE;
                    end else if (!i_status.out_busy) begin
                        r_cmd.emit_read <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_LVL: begin
                    if (r_cmd.inc_lvl || r_cmd.roll_lvl) begin
                        r_state <= S_LVL;
                    end else if (!i_status.lvl_closes) begin
                        if (i_status.lvl_last) r_state <= S_DONE;
                        else r_cmd.inc_lvl <= 1'b1;
                    end else if (i_status.no_keys) begin
                        r_state <= S_ROLL;
                    end else begin
                        r_cmd.clr_key <= 1'b1;
                        r_state       <= S_KRD;
                    end
                end
                S_KRD: begin
                    r_cmd.rd_req <= 1'b1;
                    r_state      <= S_KWAIT;
                end
                S_KWAIT: r_state <= S_KEXEC;
                S_KEXEC: begin
                    if (!(i_status.alarm_hit && i_status.out_busy)) begin
                        r_cmd.emit_alarm <= i_status.alarm_hit;
                        r_cmd.sweep_wr   <= 1'b1;
                        if (i_status.key_last) begin
                            r_state <= S_ROLL;
                        end else begin
                            r_cmd.inc_key <= 1'b1;
                            r_state       <= S_KRD;
                        end
                    end
                end
                S_ROLL: begin
                    if (!r_cmd.sweep_wr) begin
                        r_cmd.roll_lvl <= 1'b1;
                        if (i_status.lvl_last) r_state <= S_DONE;
                        else begin
                            r_cmd.inc_lvl <= 1'b1;
                            r_state       <= S_LVL;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_status.out_busy && !r_cmd.roll_lvl && !r_cmd.do_add
                        && !r_cmd.do_thr) begin
                        r_cmd.emit_done <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // requests are only taken from idle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |-> (r_state == S_IDLE)) else $error("latch outside idle");
    // at most one result per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit_alarm, o_cmd.emit_done, o_cmd.emit_read}))
        else $error("two results at once");
    // a sweep write follows the execute step of its key
    a_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_wr |-> $past(r_state == S_KEXEC)) else $error("sweep without read");

endmodule

### hdl/windowed_counter_statistics.sv
// ----------------------------------------------------------------------------
// windowed_counter_statistics
// per-key event counters over four time windows with alarms and statistics
// ----------------------------------------------------------------------------
// Requests enter on the input channel (valid/stall) and results leave on the
// output channel (valid/stall); configuration is a valid/ready write port,
// always ready; user must write it only while the block is idle (unenforced).
// One request is worked at a time. Steps from accept to result:
//   add    read, wait and write at each level in turn, then the result
//   thresh read, wait, write; read: read, wait, then the result
//   tick   a close test at each level; for each closing level, read, wait
//          and update every active key, then roll the level
// A new request is taken in the cycle the result is loaded.
// The output register holds a result while the receiver stalls; the sweep
// waits on it before issuing the next alarm, so nothing is lost.
// Synchronous reset clears configuration to its defaults, all window state
// and, through per-entry valid bits, every counter, so no clearing pass.
// ----------------------------------------------------------------------------
module windowed_counter_statistics #(
    parameter int KEYS   = wcs_pkg::KeysDefault,
    parameter int LEVELS = wcs_pkg::LevelsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wcs_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [wcs_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_level,
    input  logic [2:0]                    i_key_index,
    input  logic [2:0]                    i_stat_kind,
    input  logic [31:0]                   i_amount,
    input  logic [47:0]                   i_now_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_result_kind,
    output logic [1:0]                    o_alarm_level,
    output logic [2:0]                    o_alarm_key,
    output logic [31:0]                   o_count_value,
    output logic [31:0]                   o_threshold_value,
    output logic [3:0]                    o_rolled_mask,
    output logic                          o_last_of_run
);
    import wcs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    wcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // storage and arithmetic
    wcs_datapath #(.KEYS(KEYS), .LEVELS(LEVELS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_level           (i_level),
        .i_key_index       (i_key_index),
        .i_stat_kind       (i_stat_kind),
        .i_amount          (i_amount),
        .i_now_time        (i_now_time),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_alarm_level     (o_alarm_level),
        .o_alarm_key       (o_alarm_key),
        .o_count_value     (o_count_value),
        .o_threshold_value (o_threshold_value),
        .o_rolled_mask     (o_rolled_mask),
        .o_last_of_run     (o_last_of_run)
    );

endmodule
